@@ sv/hgcd_pkg.sv @@
// hgcd_pkg: shared widths, constants, types and helper functions for the
// haversine distance unit; used by every module in the sv folder
`timescale 1ns / 1ps

package hgcd_pkg;

  localparam int ANGLE_FRAC_BITS   = 20;
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int CW                = 34;
  localparam int RAD_W             = 23;
  localparam int DIST_W            = 25;
  localparam int ROOT_W            = 31;
  localparam int REM_W             = 64;
  localparam int ANG_W             = 29;
  localparam int PROD_W            = 57;
  localparam int A_W               = 31;

  localparam logic [RAD_W-1:0]         RADIUS_RESET = RAD_W'(6371000);
  localparam logic signed [27:0]       DEG2RAD_Q32  = 28'sd74961321;
  localparam logic signed [CW-1:0]     GAIN_Q30     = CW'(652032874);
  localparam logic signed [CW-1:0]     HALF_PI_Q30  = CW'(1686629713);
  localparam logic [A_W-1:0]           ONE_Q30      = A_W'(1) << 30;
  localparam logic                     REG_RADIUS   = 1'b0;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                    flip;
    logic signed [ANG_W-1:0] ang;
  } fold_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0: v = CW'(843314856);
      1: v = CW'(497837829);
      2: v = CW'(263043836);
      3: v = CW'(133525158);
      4: v = CW'(67021686);
      5: v = CW'(33543515);
      6: v = CW'(16775850);
      7: v = CW'(8388437);
      8: v = CW'(4194282);
      9: v = CW'(2097149);
      default: v = (i <= 30) ? ((CW'(1) << (30 - i)) - CW'(1)) : '0;
    endcase
    return v;
  endfunction

  // wrap into one turn, then fold into a quarter turn
  function automatic fold_t fold_deg(input logic signed [31:0] v, input int fb);
    logic signed [31:0] half;
    logic signed [31:0] turn;
    logic signed [31:0] quarter;
    logic signed [31:0] r;
    fold_t f;
    half    = 32'sd180 <<< fb;
    turn    = 32'sd360 <<< fb;
    quarter = 32'sd90 <<< fb;
    r       = v;
    f.flip  = 1'b0;
    if (r >= half) begin
      r = r - turn;
    end else if (r < -half) begin
      r = r + turn;
    end
    if (r > quarter) begin
      r      = half - r;
      f.flip = 1'b1;
    end else if (r < -quarter) begin
      r      = -half - r;
      f.flip = 1'b1;
    end
    f.ang = ANG_W'(r);
    return f;
  endfunction

  function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    p = (p + ((2*CW)'(1) <<< 29)) >>> 30;
    return CW'(p);
  endfunction

endpackage

@@ sv/hgcd_cordic_cell.sv @@
// hgcd_cordic_cell: one registered CORDIC micro-rotation, rotation or vectoring
// depends on hgcd_pkg
`timescale 1ns / 1ps

module hgcd_cordic_cell #(
  parameter int Stage     = 0,
  parameter bit Vectoring = 1'b0
) (
  input  logic              clk_i,
  input  hgcd_pkg::cordic_t cell_i,
  output hgcd_pkg::cordic_t cell_o
);
  import hgcd_pkg::*;

  localparam logic signed [CW-1:0] Atan = atan_q30(Stage);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic                 turn_neg;
  cordic_t              res_d;
  cordic_t              res_q;

  always_comb begin
    dx       = cell_i.y >>> Stage;
    dy       = cell_i.x >>> Stage;
    turn_neg = Vectoring ? (cell_i.y > 0) : (cell_i.z < 0);
    if (turn_neg) begin
      res_d.x = cell_i.x + dx;
      res_d.y = cell_i.y - dy;
      res_d.z = cell_i.z + Atan;
    end else begin
      res_d.x = cell_i.x - dx;
      res_d.y = cell_i.y + dy;
      res_d.z = cell_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign cell_o = res_q;

endmodule

@@ sv/hgcd_sqrt_cell.sv @@
// hgcd_sqrt_cell: one registered bit of a restoring integer square root
// depends on hgcd_pkg
`timescale 1ns / 1ps

module hgcd_sqrt_cell #(
  parameter int Bit = 0
) (
  input  logic            clk_i,
  input  hgcd_pkg::sqrt_t cell_i,
  output hgcd_pkg::sqrt_t cell_o
);
  import hgcd_pkg::*;

  logic [REM_W-1:0] trial;
  sqrt_t            res_d;
  sqrt_t            res_q;

  always_comb begin
    trial = (REM_W'(cell_i.root) << (Bit + 1)) + (REM_W'(1) << (2 * Bit));
    res_d = cell_i;
    if (cell_i.rem >= trial) begin
      res_d.rem  = cell_i.rem - trial;
      res_d.root = cell_i.root | (ROOT_W'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign cell_o = res_q;

endmodule

@@ sv/haversine_great_circle_distance_unit.sv @@
// haversine_great_circle_distance_unit: fully pipelined great-circle distance
// depends on hgcd_pkg, hgcd_cordic_cell, hgcd_sqrt_cell
//
// usage
// a request carries two points (lon/lat, signed degrees, 20 fraction bits) on
// lon_a_i, lat_a_i, lon_b_i, lat_b_i and is taken at a clock edge where start
// is high and busy is low; busy never rises, so a request can be given in
// every cycle
// the distance in metres appears on distance_m_o for one cycle with done
// high, in request order; throughput is one request per cycle
// the latency is set by the two CORDIC cell rows (sine/cosine and atan2)
// and the 31-cell square root row, plus seven multiply and fold stages
// the receiver cannot stall: each result is valid for exactly one cycle
// the sphere radius sits at byte addresses 0 to 3 of the APB port; the user
// must see that it is written while no request is in flight, which the block
// itself does not enforce
// reset clears the pipeline valid line and sets the radius to 6371000 m
`timescale 1ns / 1ps

module haversine_great_circle_distance_unit #(
  parameter int CORDIC_STAGES = hgcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [28:0]               lon_a_i,
  input  logic signed [27:0]               lat_a_i,
  input  logic signed [28:0]               lon_b_i,
  input  logic signed [27:0]               lat_b_i,
  output logic                             done_o,
  output logic [hgcd_pkg::DIST_W-1:0]      distance_m_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import hgcd_pkg::*;

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = 2 * N + 38;

  logic [RAD_W-1:0]      radius_q;
  logic [LAT-1:0]        vld_q;
  fold_t                 fold_d [4];
  fold_t                 fold_q [4];
  logic signed [PROD_W-1:0] rad_q [4];
  logic [1:0]            flip_q [N+2];
  cordic_t               rot_w  [4][N+1];
  logic signed [CW-1:0]  c1;
  logic signed [CW-1:0]  c2;
  logic signed [CW-1:0]  p1_q;
  logic signed [CW-1:0]  p2_q;
  logic signed [CW-1:0]  p3_q;
  logic signed [CW-1:0]  p1d_q;
  logic signed [CW-1:0]  p4_q;
  logic signed [CW:0]    a_sum;
  logic [A_W-1:0]        a_q;
  sqrt_t                 sq_w   [2][ROOT_W+1];
  cordic_t               vec_w  [N+1];
  logic [A_W-1:0]        zc;
  logic [RAD_W+A_W-1:0]  dprod_q;
  logic [DIST_W-1:0]     dist_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIUS)) begin
      radius_q <= pwdata[RAD_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RADIUS: prdata = 32'(radius_q);
      default:    prdata = '0;
    endcase
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start & ~busy};
    end
  end

  // fold the half-differences and latitudes
  always_comb begin
    fold_d[0] = fold_deg(32'(lat_b_i) - 32'(lat_a_i), ANGLE_FRAC_BITS + 1);
    fold_d[1] = fold_deg(32'(lon_b_i) - 32'(lon_a_i), ANGLE_FRAC_BITS + 1);
    fold_d[2] = fold_deg(32'(lat_a_i), ANGLE_FRAC_BITS);
    fold_d[3] = fold_deg(32'(lat_b_i), ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    fold_q    <= fold_d;
    flip_q[0] <= {fold_d[3].flip, fold_d[2].flip};
    for (int k = 0; k < 4; k++) begin
      rad_q[k] <= PROD_W'(fold_q[k].ang) * PROD_W'(DEG2RAD_Q32);
    end
    for (int k = 1; k < N + 2; k++) begin
      flip_q[k] <= flip_q[k-1];
    end
  end

  // degrees to radians, then sine and cosine rows
  for (genvar k = 0; k < 4; k++) begin : g_rot
    localparam int Shift = (k < 2) ? ANGLE_FRAC_BITS + 3 : ANGLE_FRAC_BITS + 2;

    assign rot_w[k][0].x = GAIN_Q30;
    assign rot_w[k][0].y = '0;
    assign rot_w[k][0].z = CW'((rad_q[k] + (PROD_W'(1) <<< (Shift - 1))) >>> Shift);

    for (genvar i = 0; i < N; i++) begin : g_cell
      hgcd_cordic_cell #(.Stage(i), .Vectoring(1'b0)) u_cell (
        .clk_i  (clk_i),
        .cell_i (rot_w[k][i]),
        .cell_o (rot_w[k][i+1])
      );
    end
  end

  // haversine term a
  assign c1 = flip_q[N+1][0] ? -rot_w[2][N].x : rot_w[2][N].x;
  assign c2 = flip_q[N+1][1] ? -rot_w[3][N].x : rot_w[3][N].x;
  assign a_sum = (CW+1)'(p1d_q) + (CW+1)'(p4_q);

  always_ff @(posedge clk_i) begin
    p1_q  <= mulq(rot_w[0][N].y, rot_w[0][N].y);
    p2_q  <= mulq(c1, c2);
    p3_q  <= mulq(rot_w[1][N].y, rot_w[1][N].y);
    p1d_q <= p1_q;
    p4_q  <= mulq(p2_q, p3_q);
    if (a_sum < 0) begin
      a_q <= '0;
    end else if (a_sum > (CW+1)'(ONE_Q30)) begin
      a_q <= ONE_Q30;
    end else begin
      a_q <= A_W'(a_sum);
    end
  end

  // square roots of a and 1-a
  assign sq_w[0][0].rem  = REM_W'(a_q) << 30;
  assign sq_w[0][0].root = '0;
  assign sq_w[1][0].rem  = REM_W'(ONE_Q30 - a_q) << 30;
  assign sq_w[1][0].root = '0;

  for (genvar k = 0; k < 2; k++) begin : g_sqrt
    for (genvar j = 0; j < ROOT_W; j++) begin : g_cell
      hgcd_sqrt_cell #(.Bit(ROOT_W - 1 - j)) u_cell (
        .clk_i  (clk_i),
        .cell_i (sq_w[k][j]),
        .cell_o (sq_w[k][j+1])
      );
    end
  end

  // atan2 row
  assign vec_w[0].x = CW'(sq_w[1][ROOT_W].root);
  assign vec_w[0].y = CW'(sq_w[0][ROOT_W].root);
  assign vec_w[0].z = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    hgcd_cordic_cell #(.Stage(i), .Vectoring(1'b1)) u_cell (
      .clk_i  (clk_i),
      .cell_i (vec_w[i]),
      .cell_o (vec_w[i+1])
    );
  end

  // scale by the radius
  always_comb begin
    if (vec_w[N].z < 0) begin
      zc = '0;
    end else if (vec_w[N].z > HALF_PI_Q30) begin
      zc = A_W'(HALF_PI_Q30);
    end else begin
      zc = A_W'(vec_w[N].z);
    end
  end

  always_ff @(posedge clk_i) begin
    dprod_q <= (RAD_W+A_W)'(radius_q) * (RAD_W+A_W)'(zc);
    dist_q  <= DIST_W'(((RAD_W+A_W+1)'(dprod_q) << 1) + ((RAD_W+A_W+1)'(1) << 29) >> 30);
  end

  assign done_o       = vld_q[LAT-1];
  assign distance_m_o = dist_q;

endmodule

@@ sv/hgcd_checker.sv @@
// hgcd_checker: port-level checks of the haversine distance unit, bound to it
// depends on hgcd_pkg and haversine_great_circle_distance_unit
`timescale 1ns / 1ps

module hgcd_checker #(
  parameter int CORDIC_STAGES = hgcd_pkg::CORDIC_STAGES_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [hgcd_pkg::DIST_W-1:0] distance_m_o,
  input logic                        pready
);
  import hgcd_pkg::*;

  localparam int LAT = 2 * CORDIC_STAGES + 38;

  // every request gives one result after the fixed latency
  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result missing after request");

  // no result without a request
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##LAT !done_o)
    else $error("result without request");

  // distance never exceeds half a circumference of the largest sphere
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (distance_m_o <= DIST_W'(26353589)))
    else $error("distance out of range");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && !busy)
    else $error("unit stalled");

endmodule

bind haversine_great_circle_distance_unit hgcd_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_hgcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .distance_m_o (distance_m_o),
  .pready       (pready)
);
